/* design/sosf_pkg.sv */
// Shared definitions for the second-order smoothing filter.
// Holds field widths, register indexes, microcode word layout and the control ROM.
// No dependencies.
package sosf_pkg;

    // Field and register widths
    localparam int DATA_WIDTH_DEF = 32;
    localparam int BW_W           = 24;
    localparam int XI_W           = 20;
    localparam int DT_W           = 24;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd2;

    // Reset values of the registers
    localparam logic [BW_W-1:0] BW_RESET = 24'd65536;
    localparam logic [XI_W-1:0] XI_RESET = 20'd65536;
    localparam logic [DT_W-1:0] DT_RESET = 24'd16777;

    // Arithmetic geometry: gains are Q.32, time step is Q0.24
    localparam int GAIN_W    = 48;
    localparam int DIG_W     = 16;
    localparam int GAIN_FRAC = 32;
    localparam int DT_FRAC   = 24;
    localparam int TERM_W    = 62;
    localparam int SUM_W     = TERM_W + 2;
    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

    // Digit counts of the multiplicand for the serial multiply
    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] DIGS_GAIN  = 2'd3;
    localparam logic [CNT_W-1:0] DIGS_SHORT = 2'd2;

    // Operand A sources
    localparam logic [1:0] A_BW    = 2'd0;
    localparam logic [1:0] A_ERR   = 2'd1;
    localparam logic [1:0] A_VEL   = 2'd2;
    localparam logic [1:0] A_ACCEL = 2'd3;

    // Operand B sources
    localparam logic [2:0] B_BW = 3'd0;
    localparam logic [2:0] B_XI = 3'd1;
    localparam logic [2:0] B_KP = 3'd2;
    localparam logic [2:0] B_KD = 3'd3;
    localparam logic [2:0] B_DT = 3'd4;

    // Rounding shift select
    localparam logic RND_GAIN = 1'b0;
    localparam logic RND_DT   = 1'b1;

    // Writeback destinations
    localparam logic [2:0] WB_NONE  = 3'd0;
    localparam logic [2:0] WB_KP    = 3'd1;
    localparam logic [2:0] WB_KD    = 3'd2;
    localparam logic [2:0] WB_T1    = 3'd3;
    localparam logic [2:0] WB_ACCEL = 3'd4;
    localparam logic [2:0] WB_VEL   = 3'd5;
    localparam logic [2:0] WB_POS   = 3'd6;

    // Sequencing conditions
    localparam logic [1:0] C_NEXT = 2'd0;
    localparam logic [1:0] C_LOOP = 2'd1;
    localparam logic [1:0] C_SKIP = 2'd2;
    localparam logic [1:0] C_EMIT = 2'd3;

    // Program addresses
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] ST_KP_LD    = 5'd0;
    localparam logic [PC_W-1:0] ST_KP_MAC   = 5'd1;
    localparam logic [PC_W-1:0] ST_KD_LD    = 5'd2;
    localparam logic [PC_W-1:0] ST_KD_MAC   = 5'd3;
    localparam logic [PC_W-1:0] ST_KD_WB    = 5'd4;
    localparam logic [PC_W-1:0] ST_P_LD     = 5'd5;
    localparam logic [PC_W-1:0] ST_P_MAC    = 5'd6;
    localparam logic [PC_W-1:0] ST_P_RND    = 5'd7;
    localparam logic [PC_W-1:0] ST_D_MAC    = 5'd8;
    localparam logic [PC_W-1:0] ST_D_RND    = 5'd9;
    localparam logic [PC_W-1:0] ST_ACC_WB   = 5'd10;
    localparam logic [PC_W-1:0] ST_V_LD     = 5'd11;
    localparam logic [PC_W-1:0] ST_V_MAC    = 5'd12;
    localparam logic [PC_W-1:0] ST_V_RND    = 5'd13;
    localparam logic [PC_W-1:0] ST_V_WB     = 5'd14;
    localparam logic [PC_W-1:0] ST_X_LD     = 5'd15;
    localparam logic [PC_W-1:0] ST_X_MAC    = 5'd16;
    localparam logic [PC_W-1:0] ST_X_RND    = 5'd17;
    localparam logic [PC_W-1:0] ST_X_WB     = 5'd18;

    // One microcode word
    typedef struct packed {
        logic            ld_en;
        logic [1:0]      a_sel;
        logic [2:0]      b_sel;
        logic            mac_en;
        logic            rnd_en;
        logic            rnd_sel;
        logic [2:0]      wb_sel;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic   start;
        logic   exec;
        logic   emit;
        ucode_t uw;
    } dp_ctl_t;

    // Control ROM: one word per program step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            ST_KP_LD: begin
                w.ld_en = 1'b1; w.a_sel = A_BW; w.b_sel = B_BW;
                w.cond = C_SKIP; w.target = ST_P_LD;
            end
            ST_KP_MAC: begin
                w.mac_en = 1'b1; w.cond = C_LOOP;
            end
            ST_KD_LD: begin
                w.wb_sel = WB_KP;
                w.ld_en = 1'b1; w.a_sel = A_BW; w.b_sel = B_XI;
            end
            ST_KD_MAC: begin
                w.mac_en = 1'b1; w.cond = C_LOOP;
            end
            ST_KD_WB: begin
                w.wb_sel = WB_KD;
            end
            ST_P_LD: begin
                w.ld_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_KP;
            end
            ST_P_MAC: begin
                w.mac_en = 1'b1; w.cond = C_LOOP;
            end
            ST_P_RND: begin
                w.rnd_en = 1'b1; w.rnd_sel = RND_GAIN;
                w.ld_en = 1'b1; w.a_sel = A_VEL; w.b_sel = B_KD;
            end
            ST_D_MAC: begin
                w.mac_en = 1'b1; w.wb_sel = WB_T1; w.cond = C_LOOP;
            end
            ST_D_RND: begin
                w.rnd_en = 1'b1; w.rnd_sel = RND_GAIN;
            end
            ST_ACC_WB: begin
                w.wb_sel = WB_ACCEL;
            end
            ST_V_LD: begin
                w.ld_en = 1'b1; w.a_sel = A_ACCEL; w.b_sel = B_DT;
            end
            ST_V_MAC: begin
                w.mac_en = 1'b1; w.cond = C_LOOP;
            end
            ST_V_RND: begin
                w.rnd_en = 1'b1; w.rnd_sel = RND_DT;
            end
            ST_V_WB: begin
                w.wb_sel = WB_VEL;
            end
            ST_X_LD: begin
                w.ld_en = 1'b1; w.a_sel = A_VEL; w.b_sel = B_DT;
            end
            ST_X_MAC: begin
                w.mac_en = 1'b1; w.cond = C_LOOP;
            end
            ST_X_RND: begin
                w.rnd_en = 1'b1; w.rnd_sel = RND_DT;
            end
            ST_X_WB: begin
                w.wb_sel = WB_POS; w.cond = C_EMIT;
            end
            default: begin
                w.cond = C_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/sosf_sequencer.sv */
// Microcode sequencer of the second-order smoothing filter.
// Step counter, loop counter, conditional jumps and both handshakes.
// Depends on sosf_pkg.
module sosf_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sosf_pkg::dp_ctl_t ctl
);

    logic [sosf_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [sosf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       gains_ok_reg, gains_ok_next;
    logic                       m_valid_reg, m_valid_next;
    sosf_pkg::ucode_t           uw;
    logic                       stall;
    logic                       exec;
    logic                       start;
    logic                       emit;

    // Fetch the control word of the current step
    assign uw    = sosf_pkg::ucode_rom(pc_reg);
    assign start = s_valid && !busy_reg;
    assign stall = (uw.cond == sosf_pkg::C_EMIT) && m_valid_reg && !m_ready;
    assign exec  = busy_reg && !stall;
    assign emit  = exec && (uw.cond == sosf_pkg::C_EMIT);

    assign s_ready   = !busy_reg;
    assign m_valid   = m_valid_reg;
    assign ctl.start = start;
    assign ctl.exec  = exec;
    assign ctl.emit  = emit;
    assign ctl.uw    = uw;

    // Advance the step counter and the digit loop
    always_comb begin
        pc_next       = pc_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        gains_ok_next = gains_ok_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            gains_ok_next = 1'b0;
        end

        if (start) begin
            busy_next = 1'b1;
            pc_next   = sosf_pkg::ST_KP_LD;
        end else if (exec) begin
            if (uw.ld_en) begin
                if (uw.b_sel == sosf_pkg::B_KP || uw.b_sel == sosf_pkg::B_KD) begin
                    cnt_next = sosf_pkg::DIGS_GAIN;
                end else begin
                    cnt_next = sosf_pkg::DIGS_SHORT;
                end
            end
            if (uw.wb_sel == sosf_pkg::WB_KD) begin
                gains_ok_next = 1'b1;
            end
            case (uw.cond)
                sosf_pkg::C_NEXT: begin
                    pc_next = pc_reg + sosf_pkg::PC_W'(1);
                end
                sosf_pkg::C_LOOP: begin
                    cnt_next = cnt_reg - sosf_pkg::CNT_W'(1);
                    if (cnt_reg == sosf_pkg::CNT_W'(1)) begin
                        pc_next = pc_reg + sosf_pkg::PC_W'(1);
                    end
                end
                sosf_pkg::C_SKIP: begin
                    if (gains_ok_reg) begin
                        pc_next = uw.target;
                    end else begin
                        pc_next = pc_reg + sosf_pkg::PC_W'(1);
                    end
                end
                sosf_pkg::C_EMIT: begin
                    busy_next    = 1'b0;
                    pc_next      = sosf_pkg::ST_KP_LD;
                    m_valid_next = 1'b1;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= sosf_pkg::ST_KP_LD;
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            gains_ok_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            cnt_reg      <= cnt_next;
            busy_reg     <= busy_next;
            gains_ok_reg <= gains_ok_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

/* design/sosf_datapath.sv */
// Datapath of the second-order smoothing filter: registers, digit-serial
// multiply-accumulate, rounding with cap, add with saturation, result beat.
// Depends on sosf_pkg.
module sosf_datapath #(
    parameter int DATA_WIDTH = sosf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sosf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sosf_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic signed [DATA_WIDTH-1:0]        s_sample,
    input  sosf_pkg::dp_ctl_t                   ctl,
    output logic signed [DATA_WIDTH-1:0]        m_position_out,
    output logic signed [DATA_WIDTH-1:0]        m_velocity_out,
    output logic signed [DATA_WIDTH-1:0]        m_acceleration_out
);

    localparam int ERR_W = DATA_WIDTH + 1;
    localparam int A_W   = (ERR_W > sosf_pkg::BW_W) ? ERR_W : sosf_pkg::BW_W;
    localparam int ACC_W = A_W + sosf_pkg::GAIN_W;
    localparam int RS_W  = (ACC_W + 1 > sosf_pkg::TERM_W + 1) ? ACC_W + 1
                                                              : sosf_pkg::TERM_W + 1;
    localparam int P_W   = A_W + sosf_pkg::DIG_W;
    localparam int SUM_W = sosf_pkg::SUM_W;
    localparam int GW    = sosf_pkg::GAIN_W;
    localparam int DG    = sosf_pkg::DIG_W;
    localparam int TW    = sosf_pkg::TERM_W;

    localparam logic [SUM_W-1:0] SAT_HI = {{(SUM_W-DATA_WIDTH+1){1'b0}},
                                           {(DATA_WIDTH-1){1'b1}}};
    localparam logic [SUM_W-1:0] SAT_LO = {{(SUM_W-DATA_WIDTH+1){1'b1}},
                                           {(DATA_WIDTH-1){1'b0}}};

    // Configuration registers
    logic [sosf_pkg::BW_W-1:0] bw_reg;
    logic [sosf_pkg::XI_W-1:0] xi_reg;
    logic [sosf_pkg::DT_W-1:0] dt_reg;

    // Filter state and working registers
    logic [DATA_WIDTH-1:0] pos_reg, vel_reg, accel_reg;
    logic [ERR_W-1:0]      err_reg;
    logic [GW-1:0]         kp_reg, kd_reg;
    logic [A_W-1:0]        opa_reg, opa_next;
    logic                  sign_reg, sign_next;
    logic [GW-1:0]         opb_reg, opb_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [TW-1:0]         term_reg, term_next;
    logic                  term_neg_reg;
    logic [TW:0]           t1_reg;
    logic [DATA_WIDTH-1:0] pos_out_reg, vel_out_reg, accel_out_reg;

    logic [ERR_W-1:0]      a_src;
    logic [ERR_W-1:0]      a_mag;
    logic [P_W-1:0]        prod;
    logic [RS_W-1:0]       rsum;
    logic [RS_W-1:0]       rshift;
    logic [SUM_W-1:0]      base;
    logic [SUM_W-1:0]      term_ext;
    logic                  eff_neg;
    logic [SUM_W-1:0]      sum;
    logic [DATA_WIDTH-1:0] sat_val;

    // Select and take the magnitude of operand A
    always_comb begin
        case (ctl.uw.a_sel)
            sosf_pkg::A_ERR:   a_src = err_reg;
            sosf_pkg::A_VEL:   a_src = {vel_reg[DATA_WIDTH-1], vel_reg};
            sosf_pkg::A_ACCEL: a_src = {accel_reg[DATA_WIDTH-1], accel_reg};
            default:           a_src = '0;
        endcase
        a_mag = a_src[ERR_W-1] ? (~a_src + ERR_W'(1)) : a_src;
        if (ctl.uw.a_sel == sosf_pkg::A_BW) begin
            opa_next  = A_W'(bw_reg);
            sign_next = 1'b0;
        end else begin
            opa_next  = A_W'(a_mag);
            sign_next = a_src[ERR_W-1];
        end
    end

    // Select operand B, digits taken most significant first
    always_comb begin
        case (ctl.uw.b_sel)
            sosf_pkg::B_BW: opb_next = GW'(bw_reg) << DG;
            sosf_pkg::B_XI: opb_next = GW'(xi_reg) << DG;
            sosf_pkg::B_KP: opb_next = kp_reg;
            sosf_pkg::B_KD: opb_next = kd_reg;
            sosf_pkg::B_DT: opb_next = GW'(dt_reg) << DG;
            default:        opb_next = '0;
        endcase
    end

    // One digit of multiply-accumulate
    assign prod = P_W'(opa_reg) * P_W'(opb_reg[GW-1:GW-DG]);

    always_comb begin
        if (ctl.uw.ld_en) begin
            acc_next = '0;
        end else begin
            acc_next = {acc_reg[ACC_W-DG-1:0], {DG{1'b0}}} + ACC_W'(prod);
        end
    end

    // Round the magnitude half up, drop the fraction, cap the term
    always_comb begin
        if (ctl.uw.rnd_sel == sosf_pkg::RND_DT) begin
            rsum   = RS_W'(acc_reg) + (RS_W'(1) << (sosf_pkg::DT_FRAC - 1));
            rshift = rsum >> sosf_pkg::DT_FRAC;
        end else begin
            rsum   = RS_W'(acc_reg) + (RS_W'(1) << (sosf_pkg::GAIN_FRAC - 1));
            rshift = rsum >> sosf_pkg::GAIN_FRAC;
        end
        if (rshift > RS_W'(sosf_pkg::TERM_CAP)) begin
            term_next = sosf_pkg::TERM_CAP;
        end else begin
            term_next = rshift[TW-1:0];
        end
    end

    // Add the signed term to the chosen base and saturate
    always_comb begin
        case (ctl.uw.wb_sel)
            sosf_pkg::WB_ACCEL: base = {t1_reg[TW], t1_reg};
            sosf_pkg::WB_VEL:   base = {{(SUM_W-DATA_WIDTH){vel_reg[DATA_WIDTH-1]}}, vel_reg};
            sosf_pkg::WB_POS:   base = {{(SUM_W-DATA_WIDTH){pos_reg[DATA_WIDTH-1]}}, pos_reg};
            default:            base = '0;
        endcase
        term_ext = SUM_W'(term_reg);
        eff_neg  = term_neg_reg ^ (ctl.uw.wb_sel == sosf_pkg::WB_ACCEL);
        sum      = base + (term_ext ^ {SUM_W{eff_neg}}) + SUM_W'(eff_neg);
        if ($signed(sum) > $signed(SAT_HI)) begin
            sat_val = SAT_HI[DATA_WIDTH-1:0];
        end else if ($signed(sum) < $signed(SAT_LO)) begin
            sat_val = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            sat_val = sum[DATA_WIDTH-1:0];
        end
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg <= sosf_pkg::BW_RESET;
            xi_reg <= sosf_pkg::XI_RESET;
            dt_reg <= sosf_pkg::DT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sosf_pkg::REG_BANDWIDTH: bw_reg <= cfg_wr_data[sosf_pkg::BW_W-1:0];
                sosf_pkg::REG_DAMPING:   xi_reg <= cfg_wr_data[sosf_pkg::XI_W-1:0];
                sosf_pkg::REG_TIME_STEP: dt_reg <= cfg_wr_data[sosf_pkg::DT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            vel_reg <= '0;
        end else if (ctl.exec) begin
            if (ctl.uw.wb_sel == sosf_pkg::WB_VEL) begin
                vel_reg <= sat_val;
            end
            if (ctl.uw.wb_sel == sosf_pkg::WB_POS) begin
                pos_reg <= sat_val;
            end
        end
    end

    // Working registers, executed one control word at a time
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            err_reg <= {s_sample[DATA_WIDTH-1], s_sample} - {pos_reg[DATA_WIDTH-1], pos_reg};
        end
        if (ctl.exec) begin
            if (ctl.uw.ld_en) begin
                opa_reg  <= opa_next;
                sign_reg <= sign_next;
                opb_reg  <= opb_next;
            end else if (ctl.uw.mac_en) begin
                opb_reg <= opb_reg << DG;
            end
            if (ctl.uw.ld_en || ctl.uw.mac_en) begin
                acc_reg <= acc_next;
            end
            if (ctl.uw.rnd_en) begin
                term_reg     <= term_next;
                term_neg_reg <= sign_reg;
            end
            case (ctl.uw.wb_sel)
                sosf_pkg::WB_KP:    kp_reg    <= acc_reg[GW-1:0];
                sosf_pkg::WB_KD:    kd_reg    <= {acc_reg[GW-2:0], 1'b0};
                sosf_pkg::WB_T1:    t1_reg    <= sum[TW:0];
                sosf_pkg::WB_ACCEL: accel_reg <= sat_val;
                default: begin
                end
            endcase
        end
    end

    // Capture the result beat
    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            pos_out_reg   <= sat_val;
            vel_out_reg   <= vel_reg;
            accel_out_reg <= accel_reg;
        end
    end

    assign m_position_out     = pos_out_reg;
    assign m_velocity_out     = vel_out_reg;
    assign m_acceleration_out = accel_out_reg;

endmodule

/* design/second_order_smoothing_filter.sv */
// Second-order smoothing filter (spring-damper tracker). Each input beat carries one signed
// sample; the block forms acceleration = (sample - position)*bw^2 - velocity*2*bw*xi, then
// steps velocity and position forward by the time step, and returns one result beat with
// the new position, velocity and the acceleration, all saturated to DATA_WIDTH bits.
// A microcoded sequencer drives one shared multiplier that takes a 16-bit digit of its
// second operand per cycle. The first item after any register write recomputes the gains
// bw^2 and 2*bw*xi. The next sample is taken while a finished result waits on the output;
// a result waiting longer than one item stalls the final step.
// Top level; depends on sosf_pkg, sosf_sequencer and sosf_datapath.
module second_order_smoothing_filter #(
    parameter int DATA_WIDTH = sosf_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sosf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sosf_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [DATA_WIDTH-1:0]   s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DATA_WIDTH-1:0]   m_position_out,
    output logic signed [DATA_WIDTH-1:0]   m_velocity_out,
    output logic signed [DATA_WIDTH-1:0]   m_acceleration_out
);

    sosf_pkg::dp_ctl_t ctl;

    // Step through the control program
    sosf_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ctl       (ctl)
    );

    // Execute each control word
    sosf_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_sample           (s_sample),
        .ctl                (ctl),
        .m_position_out     (m_position_out),
        .m_velocity_out     (m_velocity_out),
        .m_acceleration_out (m_acceleration_out)
    );

endmodule

/* sim/sosf_checker.sv */
// Scoreboard for the second-order smoothing filter: tracks register writes and input beats,
// integrates its own position/velocity copy and compares every result beat field by field.
// Depends on sosf_pkg for the register indexes and port widths.
`timescale 1ns / 1ps

module sosf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sosf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sosf_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [31:0]             s_sample,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [31:0]             m_position_out,
    input  logic signed [31:0]             m_velocity_out,
    input  logic signed [31:0]             m_acceleration_out,
    output int                             fail_count,
    output int                             result_count,
    output int                             pending_count
);

    localparam int GAIN_SHIFT = 32;
    localparam int STEP_SHIFT = 24;
    localparam logic [127:0] TERM_LIMIT = 128'd1 << 61;
    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;
    localparam logic [23:0] BW_INIT = 24'd65536;
    localparam logic [19:0] XI_INIT = 20'd65536;
    localparam logic [23:0] DT_INIT = 24'd16777;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
    } track_t;

    track_t             track_updates[$];
    logic [23:0]        track_bw = BW_INIT;
    logic [19:0]        track_xi = XI_INIT;
    logic [23:0]        track_dt = DT_INIT;
    logic signed [31:0] track_pos = '0;
    logic signed [31:0] track_vel = '0;
    int                 mismatch_total = 0;
    int                 beats_out = 0;

    // Signed value times unsigned gain, magnitude rounded half up, capped, sign restored
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] x,
                                                          input logic [47:0] g,
                                                          input int shift);
        logic [63:0]        mag;
        logic [127:0]       prod;
        logic signed [63:0] r;
        mag  = x[63] ? -x : x;
        prod = (128'(mag) * 128'(g) + (128'd1 << (shift - 1))) >> shift;
        if (prod > TERM_LIMIT)
            prod = TERM_LIMIT;
        r = prod[63:0];
        return x[63] ? -r : r;
    endfunction

    function automatic logic signed [31:0] clamp_word(input logic signed [63:0] v);
        if (v > WORD_MAX)
            return WORD_MAX[31:0];
        if (v < WORD_MIN)
            return WORD_MIN[31:0];
        return v[31:0];
    endfunction

    // Form the acceleration, step velocity then position, and queue the new state
    task automatic integrate_sample(input logic signed [31:0] sample);
        logic [47:0]        kp;
        logic [47:0]        kd;
        logic signed [63:0] err;
        logic signed [63:0] drive;
        track_t             upd;
        kp    = 48'(track_bw) * 48'(track_bw);
        kd    = 48'(track_bw) * 48'(track_xi) * 48'd2;
        err   = 64'(sample) - 64'(track_pos);
        drive = scaled_product(err, kp, GAIN_SHIFT)
              - scaled_product(64'(track_vel), kd, GAIN_SHIFT);
        upd.acceleration = clamp_word(drive);
        track_vel = clamp_word(64'(track_vel)
                  + scaled_product(64'(upd.acceleration), 48'(track_dt), STEP_SHIFT));
        track_pos = clamp_word(64'(track_pos)
                  + scaled_product(64'(track_vel), 48'(track_dt), STEP_SHIFT));
        upd.position = track_pos;
        upd.velocity = track_vel;
        track_updates.push_back(upd);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h (result beat %0d)",
                 $realtime, what, got, want, beats_out);
        mismatch_total++;
    endtask

    always @(posedge aclk) begin
        track_t want;
        if (!aresetn) begin
            track_updates.delete();
            track_bw  = BW_INIT;
            track_xi  = XI_INIT;
            track_dt  = DT_INIT;
            track_pos = '0;
            track_vel = '0;
        end else begin
            // Retire the oldest prediction against each result beat
            if (m_valid && m_ready) begin
                beats_out++;
                if (track_updates.size() == 0) begin
                    report_mismatch("unexpected beat", m_position_out, '0);
                end else begin
                    want = track_updates.pop_front();
                    if (m_position_out !== want.position)
                        report_mismatch("position_out", m_position_out, want.position);
                    if (m_velocity_out !== want.velocity)
                        report_mismatch("velocity_out", m_velocity_out, want.velocity);
                    if (m_acceleration_out !== want.acceleration)
                        report_mismatch("acceleration_out", m_acceleration_out,
                                        want.acceleration);
                end
            end
            if (s_valid && s_ready)
                integrate_sample(s_sample);
            // Keep only each register's low bits; unknown indexes drop
            if (cfg_wr_en) begin
                case (cfg_addr)
                    sosf_pkg::REG_BANDWIDTH: track_bw = cfg_wr_data[23:0];
                    sosf_pkg::REG_DAMPING:   track_xi = cfg_wr_data[19:0];
                    sosf_pkg::REG_TIME_STEP: track_dt = cfg_wr_data[23:0];
                    default: ;
                endcase
            end
        end
        fail_count    <= mismatch_total;
        result_count  <= beats_out;
        pending_count <= track_updates.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the second-order smoothing filter: clock, reset, register writes,
// sample stimulus with idling and a long output hold-off, and the final verdict.
// Depends on sosf_pkg, second_order_smoothing_filter and sosf_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 100;
    localparam logic [sosf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [sosf_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [sosf_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic signed [31:0]             s_sample = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic signed [31:0]             m_position_out;
    logic signed [31:0]             m_velocity_out;
    logic signed [31:0]             m_acceleration_out;

    int fail_count;
    int result_count;
    int pending_count;
    int samples_sent = 0;
    int settings_used = 1;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_ticket = 0;
    int cycle_count = 0;

    second_order_smoothing_filter dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_position_out     (m_position_out),
        .m_velocity_out     (m_velocity_out),
        .m_acceleration_out (m_acceleration_out)
    );

    sosf_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_position_out     (m_position_out),
        .m_velocity_out     (m_velocity_out),
        .m_acceleration_out (m_acceleration_out),
        .fail_count         (fail_count),
        .result_count       (result_count),
        .pending_count      (pending_count)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, result_count, samples_sent);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off each time the ticket moves
    always @(posedge aclk) begin
        int hold_served;
        int hold_left;
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offer one sample beat and hold it until accepted
    task automatic push_sample(input logic signed [31:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        samples_sent++;
    endtask

    // Drop valid and wait for every outstanding result beat
    task automatic wait_results();
        s_valid <= 1'b0;
        while (result_count < samples_sent)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sosf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sosf_pkg::CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Register value: an extreme, a full-width random, or a value in the useful range
    function automatic logic [23:0] pick_setting(input int bits, input int unsigned lo,
                                                 input int unsigned hi);
        logic [23:0] mask;
        mask = 24'hFFFFFF >> (24 - bits);
        case ($urandom_range(9))
            0:       return '0;
            1:       return mask;
            2, 3:    return 24'($urandom()) & mask;
            default: return 24'($urandom_range(hi, lo));
        endcase
    endfunction

    initial begin
        logic signed [31:0] walk;
        logic signed [31:0] smp;
        logic [23:0]        bw;
        logic [23:0]        xi;
        logic [23:0]        dt;
        walk = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: full-scale steps and small values
        src_idle_pct = 27;
        snk_idle_pct = 85;
        push_sample(32'sh0000_0000);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000);
        push_sample(32'sh8000_0000);
        push_sample(32'shFFFF_FFFF);
        push_sample(32'sh0000_0001);
        push_sample(32'sh0001_0000);
        wait_results();

        // Largest gains and step: drive every sum into saturation
        write_reg(sosf_pkg::REG_BANDWIDTH, 24'hFFFFFF);
        write_reg(sosf_pkg::REG_DAMPING, 24'h0FFFFF);
        write_reg(sosf_pkg::REG_TIME_STEP, 24'hFFFFFF);
        settings_used++;
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh0000_0000);
        wait_results();

        // Zero step holds the state; a write to the spare index changes nothing
        write_reg(sosf_pkg::REG_TIME_STEP, 24'h000000);
        write_reg(REG_NONE, 24'hFFFFFF);
        settings_used++;
        push_sample(32'sh1234_5678);
        push_sample(32'sh8000_0000);
        push_sample(32'sh0000_0000);
        wait_results();

        // Zero bandwidth with a damping write whose top bits must be dropped
        write_reg(sosf_pkg::REG_BANDWIDTH, 24'h000000);
        write_reg(sosf_pkg::REG_DAMPING, 24'hF08000);
        write_reg(sosf_pkg::REG_TIME_STEP, 24'hFFFFFF);
        settings_used++;
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh0000_0001);
        wait_results();

        // Ordinary tracking settings
        write_reg(sosf_pkg::REG_BANDWIDTH, 24'h0A0000);
        write_reg(sosf_pkg::REG_DAMPING, 24'h010000);
        write_reg(sosf_pkg::REG_TIME_STEP, 24'd167770);
        settings_used++;
        push_sample(32'sh0064_0000);
        push_sample(32'sh0064_0000);
        push_sample(32'shFFFF_0000);
        push_sample(32'sh0000_0000);
        wait_results();

        // Random part in three idling modes, new settings every segment
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 85 : 0;
            snk_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 27 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                bw = pick_setting(24, 65536, 2621440);
                xi = pick_setting(20, 13107, 131072);
                dt = pick_setting(24, 1677, 335544);
                write_reg(sosf_pkg::REG_BANDWIDTH, bw);
                write_reg(sosf_pkg::REG_DAMPING, {4'($urandom()), xi[19:0]});
                write_reg(sosf_pkg::REG_TIME_STEP, dt);
                if ($urandom_range(3) == 0)
                    write_reg(REG_NONE, 24'($urandom()));
                settings_used++;
                for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                    // Long output stall while samples keep coming
                    if (seg == 2 && i == 40)
                        hold_ticket <= hold_ticket + 1;
                    case ($urandom_range(9))
                        0: begin
                            case ($urandom_range(3))
                                0:       smp = 32'sh7FFF_FFFF;
                                1:       smp = 32'sh8000_0000;
                                2:       smp = '0;
                                default: smp = -32'sd1;
                            endcase
                        end
                        1, 2, 3: smp = $urandom();
                        default: begin
                            walk = walk + 32'($urandom_range(2097152)) - 32'd1048576;
                            smp  = walk;
                        end
                    endcase
                    push_sample(smp);
                end
                wait_results();
            end
        end

        // Let any stray beat show up before the verdict
        repeat (64) @(posedge aclk);
        $display("Covered %0d samples under %0d register settings, three idling modes,",
                 samples_sent, settings_used);
        $display("saturation, zero time step, masked and ignored writes, and long output stalls.");
        if (fail_count == 0 && pending_count == 0 && result_count == samples_sent) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("mismatches %0d, pending %0d, results %0d of %0d",
                     fail_count, pending_count, result_count, samples_sent);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
